>>> rtl/palette_color_cycling_engine_macros.svh
// Assertion macros for the palette color cycling engine.
`ifndef PALETTE_COLOR_CYCLING_ENGINE_MACROS_SVH
`define PALETTE_COLOR_CYCLING_ENGINE_MACROS_SVH
`ifndef SYNTH
`define PCCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcce assertion failed");
`define PCCE_ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pcce assertion failed");
`else
`define PCCE_ASSERT(label, clk, rst_n, prop)
`define PCCE_ASSERT_CLK(label, clk, prop)
`endif
`endif

>>> rtl/pcce_pkg.sv
// Shared codes, constants and control types of the palette color cycling engine.
package pcce_pkg;

    localparam logic [1:0] ACT_BASE = 2'd0;
    localparam logic [1:0] ACT_DESC = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_LOOK = 2'd3;

    localparam int          RATE_NUM_W   = 30;
    localparam logic [29:0] RATE_NUM     = 30'd819200000;
    localparam int          DIV_CNT_W    = 5;
    localparam logic [4:0]  PERIOD_STEPS = 5'd30;
    localparam logic [4:0]  RATIO_STEPS  = 5'd8;

    typedef struct packed {
        logic base_wr;
        logic look_rd;
        logic desc_latch;
        logic desc_wr;
        logic tick_init;
        logic slot_eval;
        logic slot_next;
        logic rd_cur;
        logic rd_old;
        logic mix;
        logic wr_work;
    } pcce_cmd_t;

    typedef struct packed {
        logic div_done;
        logic slot_active;
        logic slot_last;
        logic entry_last;
    } pcce_stat_t;

endpackage

>>> rtl/pcce_ctrl.sv
// Sequencing state machine of the palette color cycling engine.
`include "palette_color_cycling_engine_macros.svh"
module pcce_ctrl
    import pcce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] action,
    input  pcce_stat_t stat,
    output pcce_cmd_t  cmd,
    output logic       busy,
    output logic       out_valid
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOOK = 4'd1;
    localparam logic [3:0] S_DDIV = 4'd2;
    localparam logic [3:0] S_SLOT = 4'd3;
    localparam logic [3:0] S_RDIV = 4'd4;
    localparam logic [3:0] S_RCUR = 4'd5;
    localparam logic [3:0] S_ROLD = 4'd6;
    localparam logic [3:0] S_MIX  = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (action)
                        ACT_BASE: cmd.base_wr = 1'b1;
                        ACT_DESC:
                        begin
                            cmd.desc_latch = 1'b1;
                            state_next     = S_DDIV;
                        end
                        ACT_TICK:
                        begin
                            cmd.tick_init = 1'b1;
                            state_next    = S_SLOT;
                        end
                        default:
                        begin
                            cmd.look_rd = 1'b1;
                            state_next  = S_LOOK;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                out_valid  = 1'b1;
                state_next = S_IDLE;
            end
            S_DDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.desc_wr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SLOT:
            begin
                priority if (stat.slot_active)
                begin
                    cmd.slot_eval = 1'b1;
                    state_next    = S_RDIV;
                end
                else if (stat.slot_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                end
            end
            S_RDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RCUR;
                end
            end
            S_RCUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_ROLD;
            end
            S_ROLD:
            begin
                cmd.rd_old = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr_work = 1'b1;
                priority if (!stat.entry_last)
                begin
                    state_next = S_RCUR;
                end
                else if (stat.slot_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_SLOT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PCCE_ASSERT(a_look_one_later, clk, rst_n, out_valid |-> $past(start && !busy && action == ACT_LOOK))
    `PCCE_ASSERT(a_base_single, clk, rst_n, (start && !busy && action == ACT_BASE) |=> !busy)
    `PCCE_ASSERT(a_other_busy, clk, rst_n, (start && !busy && action != ACT_BASE) |=> busy)
    `PCCE_ASSERT(a_eval_after_div, clk, rst_n, cmd.rd_cur |-> stat.div_done)

endmodule

>>> rtl/pcce_dp.sv
// Datapath of the palette color cycling engine: palettes, slots, divider, blender.
module pcce_dp
    import pcce_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_CYCLES      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pcce_cmd_t   cmd,
    output pcce_stat_t  stat,
    input  logic [7:0]  palette_index,
    input  logic [23:0] entry_color,
    input  logic [3:0]  cycle_slot,
    input  logic [7:0]  range_low,
    input  logic [7:0]  range_high,
    input  logic [15:0] cycle_rate,
    input  logic        forward,
    input  logic [31:0] time_us,
    input  logic        cfg_we,
    input  logic        cfg_data,
    output logic [23:0] out_color
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int SW = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;

    logic [23:0] base_mem [PALETTE_ENTRIES];
    logic [23:0] work_mem [PALETTE_ENTRIES];
    logic [23:0] base_q_reg;
    logic [23:0] work_q_reg;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] work_addr_reg;
    logic          oob_reg;
    logic          idx_ok;

    logic [7:0]  slot_lo_reg     [MAX_CYCLES];
    logic [7:0]  slot_hi_reg     [MAX_CYCLES];
    logic        slot_fwd_reg    [MAX_CYCLES];
    logic [15:0] slot_rate_reg   [MAX_CYCLES];
    logic [31:0] slot_period_reg [MAX_CYCLES];
    logic [31:0] slot_last_reg   [MAX_CYCLES];
    logic [7:0]  slot_off_reg    [MAX_CYCLES];
    logic [7:0]  slot_prev_reg   [MAX_CYCLES];

    logic          blend_reg;
    logic [31:0]   now_reg;
    logic [SW-1:0] slot_reg;

    logic [SW-1:0] d_slot_reg;
    logic          d_ok_reg;
    logic [7:0]    d_lo_reg;
    logic [7:0]    d_hi_reg;
    logic          d_fwd_reg;
    logic [15:0]   d_rate_reg;

    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [31:0] quo_reg;
    logic [RATE_NUM_W-1:0] dvd_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        rem_ge;

    logic [7:0] cur_idx_reg;
    logic [7:0] old_idx_reg;
    logic [7:0] dst_reg;
    logic [7:0] j_reg;
    logic [7:0] w_lo_reg;
    logic [7:0] w_hi_reg;
    logic       w_fwd_reg;
    logic [7:0] w_len_m1_reg;

    logic [23:0] cur_hold_reg;
    logic [23:0] mix_reg;
    logic [23:0] mix_val;
    logic [7:0]  ratio;
    logic [8:0]  inv_ratio;
    logic [16:0] acc [3];

    logic [7:0]  s_lo;
    logic [7:0]  s_hi;
    logic        s_fwd;
    logic [31:0] s_period;
    logic [31:0] s_last;
    logic [7:0]  s_off;
    logic [7:0]  s_prev;
    logic [7:0]  s_len_m1;
    logic [31:0] elapsed;
    logic        upd;
    logic [7:0]  off_wrap;
    logic [7:0]  new_off;
    logic [7:0]  new_prev;
    logic [17:0] rate3;

    assign idx_ok = {24'd0, palette_index} < 32'(PALETTE_ENTRIES);

    assign s_lo     = slot_lo_reg[slot_reg];
    assign s_hi     = slot_hi_reg[slot_reg];
    assign s_fwd    = slot_fwd_reg[slot_reg];
    assign s_period = slot_period_reg[slot_reg];
    assign s_last   = slot_last_reg[slot_reg];
    assign s_off    = slot_off_reg[slot_reg];
    assign s_prev   = slot_prev_reg[slot_reg];
    assign s_len_m1 = s_hi - s_lo;
    assign elapsed  = now_reg - s_last;
    assign upd      = elapsed >= s_period;
    assign off_wrap = (s_off == s_len_m1) ? 8'd0 : s_off + 8'd1;
    assign new_off  = upd ? off_wrap : s_off;
    assign new_prev = upd ? s_off : s_prev;
    assign rate3    = {1'b0, d_rate_reg, 1'b0} + {2'b00, d_rate_reg};

    assign stat.slot_active = (slot_rate_reg[slot_reg] != 16'd0) && (s_hi >= s_lo)
                              && ({24'd0, s_hi} < 32'(PALETTE_ENTRIES))
                              && (s_period != 32'd0);
    assign stat.slot_last   = slot_reg == SW'(MAX_CYCLES - 1);
    assign stat.entry_last  = j_reg == w_len_m1_reg;
    assign stat.div_done    = cnt_reg == '0;

    assign rem_sh  = {rem_reg, dvd_reg[RATE_NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.desc_latch)
        begin
            cnt_reg <= PERIOD_STEPS;
        end
        else if (cmd.slot_eval)
        begin
            cnt_reg <= RATIO_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.desc_latch)
        begin
            rem_reg <= 32'd0;
            dsr_reg <= {15'd0, cycle_rate, 1'b0} + {16'd0, cycle_rate};
            dvd_reg <= RATE_NUM;
            quo_reg <= 32'd0;
        end
        else if (cmd.slot_eval)
        begin
            rem_reg <= upd ? 32'd0 : elapsed;
            dsr_reg <= s_period;
            dvd_reg <= '0;
            quo_reg <= 32'd0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            dvd_reg <= {dvd_reg[RATE_NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[30:0], rem_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            blend_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.desc_latch)
        begin
            d_slot_reg <= SW'(cycle_slot);
            d_ok_reg   <= {28'd0, cycle_slot} < 32'(MAX_CYCLES);
            d_lo_reg   <= range_low;
            d_hi_reg   <= range_high;
            d_fwd_reg  <= forward;
            d_rate_reg <= cycle_rate;
        end
        if (cmd.tick_init)
        begin
            now_reg <= time_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (cmd.tick_init)
        begin
            slot_reg <= '0;
        end
        else if (cmd.slot_next)
        begin
            slot_reg <= slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CYCLES; i++)
            begin
                slot_lo_reg[i]     <= 8'd0;
                slot_hi_reg[i]     <= 8'd0;
                slot_fwd_reg[i]    <= 1'b0;
                slot_rate_reg[i]   <= 16'd0;
                slot_period_reg[i] <= 32'd0;
                slot_last_reg[i]   <= 32'd0;
                slot_off_reg[i]    <= 8'd0;
                slot_prev_reg[i]   <= 8'd0;
            end
        end
        else if (cmd.desc_wr && d_ok_reg)
        begin
            slot_lo_reg[d_slot_reg]     <= d_lo_reg;
            slot_hi_reg[d_slot_reg]     <= d_hi_reg;
            slot_fwd_reg[d_slot_reg]    <= d_fwd_reg;
            slot_rate_reg[d_slot_reg]   <= d_rate_reg;
            slot_period_reg[d_slot_reg] <= (rate3 == 18'd0) ? 32'd0 : quo_reg;
            slot_last_reg[d_slot_reg]   <= 32'd0;
            slot_off_reg[d_slot_reg]    <= 8'd0;
            slot_prev_reg[d_slot_reg]   <= 8'd0;
        end
        else if (cmd.slot_eval && upd)
        begin
            slot_prev_reg[slot_reg] <= s_off;
            slot_off_reg[slot_reg]  <= off_wrap;
            slot_last_reg[slot_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_eval)
        begin
            cur_idx_reg  <= s_lo + new_off;
            old_idx_reg  <= s_lo + new_prev;
            dst_reg      <= s_fwd ? s_lo : s_hi;
            j_reg        <= 8'd0;
            w_lo_reg     <= s_lo;
            w_hi_reg     <= s_hi;
            w_fwd_reg    <= s_fwd;
            w_len_m1_reg <= s_len_m1;
        end
        else if (cmd.wr_work)
        begin
            cur_idx_reg <= (cur_idx_reg == w_hi_reg) ? w_lo_reg : cur_idx_reg + 8'd1;
            old_idx_reg <= (old_idx_reg == w_hi_reg) ? w_lo_reg : old_idx_reg + 8'd1;
            dst_reg     <= w_fwd_reg ? dst_reg + 8'd1 : dst_reg - 8'd1;
            j_reg       <= j_reg + 8'd1;
        end
    end

    assign base_addr = cmd.rd_cur ? cur_idx_reg[AW-1:0] : old_idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.base_wr && idx_ok)
        begin
            base_mem[palette_index[AW-1:0]] <= entry_color;
        end
        base_q_reg <= base_mem[base_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.base_wr && idx_ok)
        begin
            work_mem[palette_index[AW-1:0]] <= entry_color;
        end
        else if (cmd.wr_work)
        begin
            work_mem[dst_reg[AW-1:0]] <= mix_reg;
        end
        if (cmd.look_rd)
        begin
            work_addr_reg <= palette_index[AW-1:0];
            oob_reg       <= !idx_ok;
        end
        work_q_reg <= work_mem[cmd.look_rd ? palette_index[AW-1:0] : work_addr_reg];
    end

    assign out_color = oob_reg ? 24'd0 : work_q_reg;

    assign ratio     = quo_reg[7:0];
    assign inv_ratio = 9'd256 - {1'b0, ratio};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = 17'(cur_hold_reg[8*k +: 8]) * 17'(ratio)
                     + 17'(base_q_reg[8*k +: 8]) * 17'(inv_ratio);
        end
        mix_val = {acc[2][15:8], acc[1][15:8], acc[0][15:8]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_old)
        begin
            cur_hold_reg <= base_q_reg;
        end
        if (cmd.mix)
        begin
            mix_reg <= blend_reg ? mix_val : cur_hold_reg;
        end
    end

endmodule

>>> rtl/palette_color_cycling_engine.sv
// Top level of the palette color cycling engine.
//
// channel   direction  handshake              payload
// command   in         start & !busy          action, palette_index, entry_color, cycle_slot,
//                                             range_low, range_high, cycle_rate, forward, time_us
// result    out        out_valid (1 cycle)    out_color
// config    in         cfg_valid & cfg_ready  cfg_data (blend enable)
//
// Base write: the engine stays idle. Lookup: result strobed the cycle after accept.
// Descriptor write: the period is computed by the 30-step serial divider.
// Tick: every slot is visited in turn; for each active slot, an 8-step ratio division,
// then read current, read previous, blend, write per entry.
// Reset clears control and slot state; blending resets on. Results cannot be stalled.
module palette_color_cycling_engine
    import pcce_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_CYCLES      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  palette_index,
    input  logic [23:0] entry_color,
    input  logic [3:0]  cycle_slot,
    input  logic [7:0]  range_low,
    input  logic [7:0]  range_high,
    input  logic [15:0] cycle_rate,
    input  logic        forward,
    input  logic [31:0] time_us,
    output logic        out_valid,
    output logic [23:0] out_color,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    pcce_cmd_t  cmd;
    pcce_stat_t stat;

    assign cfg_ready = ~busy;

    pcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    pcce_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_CYCLES      (MAX_CYCLES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .palette_index (palette_index),
        .entry_color   (entry_color),
        .cycle_slot    (cycle_slot),
        .range_low     (range_low),
        .range_high    (range_high),
        .cycle_rate    (cycle_rate),
        .forward       (forward),
        .time_us       (time_us),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .out_color     (out_color)
    );

endmodule

>>> tb/pcce_color_checker.sv
// Predictor and result checker for the palette color cycling engine.
`timescale 1ns / 100ps

module pcce_color_checker
    import pcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  palette_index,
    input  logic [23:0] entry_color,
    input  logic [3:0]  cycle_slot,
    input  logic [7:0]  range_low,
    input  logic [7:0]  range_high,
    input  logic [15:0] cycle_rate,
    input  logic        forward,
    input  logic [31:0] time_us,
    input  logic        out_valid,
    input  logic [23:0] out_color,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          fail_count,
    output int          colors_pending
);

    logic [23:0] base_pal [256];
    logic [23:0] work_pal [256];
    logic [7:0]  s_low [16];
    logic [7:0]  s_high [16];
    logic        s_fwd [16];
    logic [15:0] s_rate [16];
    logic [31:0] s_period [16];
    logic [31:0] s_last [16];
    logic [7:0]  s_off [16];
    logic [7:0]  s_prev [16];
    logic        blend_on;
    logic [23:0] color_q [$];

    assign colors_pending = color_q.size();

    function automatic logic [7:0] mix8(logic [7:0] cur, logic [7:0] old, int unsigned r);
        int unsigned acc;
        acc = cur * r + old * (256 - r);
        return acc[15:8];
    endfunction

    task automatic rotate_slot(int s, logic [31:0] now);
        int unsigned len, lo, hi, ratio, j;
        logic [31:0] elapsed;
        logic [63:0] scaled;
        logic [23:0] cur, old, c;
        lo = s_low[s];
        hi = s_high[s];
        if (s_rate[s] == 0 || hi < lo || s_period[s] == 0)
            return;
        len = hi - lo + 1;
        elapsed = now - s_last[s];
        if (elapsed >= s_period[s])
        begin
            s_prev[s] = s_off[s];
            s_off[s] = 8'((s_off[s] + 1) % len);
            s_last[s] = now;
            elapsed = 0;
        end
        scaled = (64'(elapsed) * 256) / s_period[s];
        ratio = scaled > 256 ? 256 : int'(scaled);
        for (j = 0; j < len; j++)
        begin
            cur = base_pal[lo + (s_off[s] + j) % len];
            old = base_pal[lo + (s_prev[s] + j) % len];
            c = blend_on ? {mix8(cur[23:16], old[23:16], ratio),
                            mix8(cur[15:8], old[15:8], ratio),
                            mix8(cur[7:0], old[7:0], ratio)} : cur;
            if (s_fwd[s])
                work_pal[lo + j] = c;
            else
                work_pal[hi - j] = c;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            foreach (base_pal[i])
            begin
                base_pal[i] = '0;
                work_pal[i] = '0;
            end
            foreach (s_low[i])
            begin
                s_low[i] = '0;
                s_high[i] = '0;
                s_fwd[i] = 1'b0;
                s_rate[i] = '0;
                s_period[i] = '0;
                s_last[i] = '0;
                s_off[i] = '0;
                s_prev[i] = '0;
            end
            blend_on = 1'b1;
            color_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                blend_on = cfg_data;
            if (out_valid)
            begin
                if (color_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual out_color %h",
                             $time, out_color);
                    fail_count++;
                end
                else
                begin
                    want = color_q.pop_front();
                    if (out_color !== want)
                    begin
                        $display("%0t: out_color mismatch, expected %h, actual %h",
                                 $time, want, out_color);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                case (action)
                    ACT_BASE:
                    begin
                        base_pal[palette_index] = entry_color;
                        work_pal[palette_index] = entry_color;
                    end
                    ACT_DESC:
                    begin
                        s_low[cycle_slot] = range_low;
                        s_high[cycle_slot] = range_high;
                        s_fwd[cycle_slot] = forward;
                        s_rate[cycle_slot] = cycle_rate;
                        s_period[cycle_slot] = cycle_rate != 0 ?
                            32'd819200000 / (32'd3 * cycle_rate) : '0;
                        s_last[cycle_slot] = '0;
                        s_off[cycle_slot] = '0;
                        s_prev[cycle_slot] = '0;
                    end
                    ACT_TICK:
                        for (int s = 0; s < 16; s++)
                            rotate_slot(s, time_us);
                    default:
                        color_q.push_back(work_pal[palette_index]);
                endcase
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the palette color cycling engine.
`timescale 1ns / 100ps

module tb_top;
    import pcce_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [7:0]  palette_index;
    logic [23:0] entry_color;
    logic [3:0]  cycle_slot;
    logic [7:0]  range_low;
    logic [7:0]  range_high;
    logic [15:0] cycle_rate;
    logic        forward;
    logic [31:0] time_us;
    logic        out_valid;
    logic [23:0] out_color;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    int          fail_count;
    int          colors_pending;

    bit          written [256];
    int          burst_left;
    logic [31:0] now_us;

    palette_color_cycling_engine dut (.*);
    pcce_color_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #300ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_cmd(logic [1:0] act, logic [7:0] idx, logic [23:0] col,
                            logic [3:0] slot, logic [7:0] lo, logic [7:0] hi,
                            logic [15:0] rate, logic fwd, logic [31:0] t);
        start <= 1'b1;
        action <= act;
        palette_index <= idx;
        entry_color <= col;
        cycle_slot <= slot;
        range_low <= lo;
        range_high <= hi;
        cycle_rate <= rate;
        forward <= fwd;
        time_us <= t;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        if (act == ACT_BASE)
            written[idx] = 1'b1;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
        end
    endtask

    task automatic write_base(logic [7:0] idx, logic [23:0] col);
        send_cmd(ACT_BASE, idx, col, 4'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic write_desc(logic [3:0] slot, logic [7:0] lo, logic [7:0] hi,
                              logic [15:0] rate, logic fwd);
        if (rate != 0 && hi >= lo)
            for (int i = lo; i <= hi; i++)
                if (!written[i])
                    write_base(8'(i), 24'($urandom));
        send_cmd(ACT_DESC, 8'($urandom), 24'($urandom), slot, lo, hi, rate, fwd, $urandom);
    endtask

    task automatic tick(logic [31:0] t);
        send_cmd(ACT_TICK, 8'($urandom), 24'($urandom), 4'($urandom), 8'($urandom),
                 8'($urandom), 16'($urandom), 1'($urandom), t);
    endtask

    task automatic lookup(logic [7:0] idx);
        send_cmd(ACT_LOOK, idx, 24'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(negedge clk);
        while (colors_pending != 0 || busy)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    task automatic write_blend(logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        while (!cfg_ready)
            @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_item;
        int unsigned pick, len, lo, hi, rate, idx;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            write_base(8'($urandom), 24'($urandom));
        else if (pick < 30)
        begin
            len = $urandom_range(0, 99) == 0 ? 256 : $urandom_range(1, 16);
            lo = $urandom_range(0, 256 - len);
            hi = lo + len - 1;
            if ($urandom_range(0, 6) == 0)
            begin
                hi = $urandom_range(0, 254);
                lo = $urandom_range(hi + 1, 255);
            end
            case ($urandom_range(0, 9))
                0: rate = 0;
                1: rate = 65535;
                2: rate = $urandom_range(1, 20);
                default: rate = $urandom_range(2000, 65535);
            endcase
            write_desc(4'($urandom), 8'(lo), 8'(hi), 16'(rate), 1'($urandom));
        end
        else if (pick < 48)
        begin
            case ($urandom_range(0, 9))
                0, 1: now_us = now_us;
                2, 3, 4, 5: now_us = now_us + $urandom_range(0, 5000);
                6, 7, 8: now_us = now_us + $urandom_range(0, 300000);
                default: now_us = $urandom;
            endcase
            tick(now_us);
        end
        else
        begin
            idx = $urandom_range(0, 255);
            for (int k = 0; k < 64 && !written[idx]; k++)
                idx = $urandom_range(0, 255);
            if (!written[idx])
                idx = 0;
            lookup(8'(idx));
        end
    endtask

    initial
    begin
        logic phase_blend [6];
        phase_blend = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_BASE;
        palette_index = '0;
        entry_color = '0;
        cycle_slot = '0;
        range_low = '0;
        range_high = '0;
        cycle_rate = '0;
        forward = 1'b0;
        time_us = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        burst_left = 30;
        now_us = '0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_blend(1'b1);

        write_base(8'd0, 24'h000000);
        write_base(8'd255, 24'hFFFFFF);
        for (int i = 1; i < 6; i++)
            write_base(8'(i), {8'(i * 40), 8'(255 - i * 30), 8'(i * 17)});
        for (int i = 250; i < 255; i++)
            write_base(8'(i), 24'($urandom));
        write_desc(4'd0, 8'd0, 8'd5, 16'd65535, 1'b1);
        write_desc(4'd15, 8'd250, 8'd255, 16'd1, 1'b0);
        write_desc(4'd1, 8'd9, 8'd3, 16'd3000, 1'b1);
        write_desc(4'd2, 8'd0, 8'd5, 16'd0, 1'b0);
        lookup(8'd255);
        lookup(8'd0);
        tick(32'd2000);
        lookup(8'd3);
        tick(32'd4200);
        lookup(8'd1);
        tick(32'hFFFF_FFFF);
        lookup(8'd252);
        lookup(8'd5);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_blend(phase_blend[p]);
            for (int n = 0; n < 310; n++)
                random_item();
        end

        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/pcce_pkg.sv
rtl/pcce_ctrl.sv
rtl/pcce_dp.sv
rtl/palette_color_cycling_engine.sv
tb/pcce_color_checker.sv
tb/tb_top.sv
